@@ rtl/sdd_pkg.sv @@
// ----------------------------------------------------------------------------
// Scaled decimal divider package
// Payload types, status codes and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package sdd_pkg;

  localparam int MANT_W  = 96;
  localparam int SCALE_W = 5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_POS_OVF  = 2'd1;
  localparam logic [1:0] ST_NEG_OVF  = 2'd2;
  localparam logic [1:0] ST_DIV_ZERO = 2'd3;

  typedef struct packed {
    logic [63:0]        dividend_low;
    logic [31:0]        dividend_high;
    logic [SCALE_W-1:0] dividend_scale;
    logic               dividend_negative;
    logic [63:0]        divisor_low;
    logic [31:0]        divisor_high;
    logic [SCALE_W-1:0] divisor_scale;
    logic               divisor_negative;
  } operand_t;

  typedef struct packed {
    logic [63:0]        quotient_low;
    logic [31:0]        quotient_high;
    logic [SCALE_W-1:0] quotient_scale;
    logic               quotient_negative;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic eval_top;
    logic digit;
    logic eval_low;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic trivial;
    logic mul_done;
    logic div_last;
    logic chunk_last;
    logic scale_zero;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/sdd_stream_if.sv @@
// ----------------------------------------------------------------------------
// Scaled decimal divider stream channel
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface sdd_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/sdd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Scaled decimal divider controller
// Sequences scaling, long division, digit reduction and result write.
// ----------------------------------------------------------------------------
module sdd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sdd_pkg::dp_stat_t stat,
  output sdd_pkg::dp_cmd_t  cmd
);
  import sdd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_EVTOP, S_DIGIT, S_EVLOW, S_FIN
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_MUL;
        end
        S_MUL: begin
          if (stat.trivial) state <= S_FIN;
          else if (stat.mul_done) state <= S_DIV;
        end
        S_DIV: begin
          if (stat.div_last) state <= S_EVTOP;
        end
        S_EVTOP: begin
          state <= stat.scale_zero ? S_FIN : S_DIGIT;
        end
        S_DIGIT: begin
          if (stat.chunk_last) state <= S_EVLOW;
        end
        S_EVLOW: begin
          state <= stat.scale_zero ? S_FIN : S_DIGIT;
        end
        S_FIN: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.mul      = (state == S_MUL) && !stat.trivial && !stat.mul_done;
    cmd.div_step = (state == S_DIV);
    cmd.eval_top = (state == S_EVTOP);
    cmd.digit    = (state == S_DIGIT);
    cmd.eval_low = (state == S_EVLOW);
    cmd.finish   = (state == S_FIN) && stat.out_free;
  end

endmodule

@@ rtl/sdd_datapath.sv @@
// ----------------------------------------------------------------------------
// Scaled decimal divider datapath
// Wide numerator register, restoring divider, divide-by-ten digit reducer,
// round-half-even evaluation and result register.
// ----------------------------------------------------------------------------
module sdd_datapath #(
  parameter int MAX_SCALE = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  sdd_pkg::dp_cmd_t   cmd,
  output sdd_pkg::dp_stat_t  stat,
  input  sdd_pkg::operand_t  in_payload,
  output sdd_pkg::result_t   out_payload,
  output logic               out_valid,
  input  logic               out_ready
);
  import sdd_pkg::*;

  localparam int NUM_W  = MANT_W + 8 * MAX_SCALE;
  localparam int CHUNKS = NUM_W / 8;
  localparam int MC_W   = $clog2(2 * MAX_SCALE + 1);
  localparam int BC_W   = $clog2(NUM_W);
  localparam int CC_W   = $clog2(CHUNKS);
  localparam logic [3:0] HALF_DIGIT = 4'd5;

  function automatic logic [7:0] div10(input logic [11:0] v);
    logic [24:0] p;
    p = {13'd0, v} * 25'd6554;
    return p[23:16];
  endfunction

  logic [NUM_W-1:0]   num;
  logic [MANT_W-1:0]  den;
  logic [MANT_W-1:0]  rem;
  logic [MC_W-1:0]    mul_cnt;
  logic [BC_W-1:0]    bit_cnt;
  logic [CC_W-1:0]    chunk_cnt;
  logic [3:0]         dr;
  logic               sticky;
  logic [SCALE_W-1:0] s_cur;
  logic [SCALE_W-1:0] s0;
  logic [MANT_W-1:0]  best;
  logic [SCALE_W-1:0] best_s;
  logic               found;
  logic               equal;
  logic               neg;
  logic               zdiv;
  logic               zdnd;

  logic [SCALE_W-1:0] sa, sb;
  logic [MANT_W:0]    trial;
  logic               trial_ge;
  logic [11:0]        cv;
  logic [7:0]         cq;
  logic [11:0]        cprod;
  logic [MANT_W:0]    rem2;
  logic               up, exact, fits, take;
  result_t            res_next;

  always_comb begin
    sa = (in_payload.dividend_scale > SCALE_W'(MAX_SCALE)) ?
         SCALE_W'(MAX_SCALE) : in_payload.dividend_scale;
    sb = (in_payload.divisor_scale > SCALE_W'(MAX_SCALE)) ?
         SCALE_W'(MAX_SCALE) : in_payload.divisor_scale;

    trial    = {rem, num[NUM_W-1]};
    trial_ge = trial >= {1'b0, den};

    cv    = {dr, num[NUM_W-1 -: 8]};
    cq    = div10(cv);
    cprod = {4'd0, cq} * 12'd10;

    rem2 = {rem, 1'b0};
    if (cmd.eval_top) begin
      up    = (rem2 > {1'b0, den}) || ((rem2 == {1'b0, den}) && num[0]);
      exact = (rem == '0);
    end else begin
      up    = (dr > HALF_DIGIT) || ((dr == HALF_DIGIT) && (sticky || num[0]));
      exact = !sticky && (dr == '0);
    end
    fits = (num[NUM_W-1:MANT_W] == '0) && !((&num[MANT_W-1:0]) && up);
    take = fits && (!found || ((s_cur >= s0) && exact));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      found     <= 1'b0;
      equal     <= 1'b0;
      zdiv      <= 1'b0;
      zdnd      <= 1'b0;
    end else begin
      if (cmd.load) begin
        num     <= {{(NUM_W-MANT_W){1'b0}}, in_payload.dividend_high,
                    in_payload.dividend_low};
        den     <= {in_payload.divisor_high, in_payload.divisor_low};
        rem     <= '0;
        zdiv    <= ({in_payload.divisor_high, in_payload.divisor_low} == '0);
        zdnd    <= ({in_payload.dividend_high, in_payload.dividend_low} == '0);
        neg     <= in_payload.dividend_negative ^ in_payload.divisor_negative;
        mul_cnt <= MC_W'(MAX_SCALE) + MC_W'(sb) - MC_W'(sa);
        s0      <= (sa > sb) ? (sa - sb) : '0;
        s_cur   <= SCALE_W'(MAX_SCALE);
        bit_cnt <= BC_W'(NUM_W - 1);
        found   <= 1'b0;
        equal   <= 1'b0;
      end
      if (cmd.mul) begin
        num     <= (num << 3) + (num << 1);
        mul_cnt <= mul_cnt - 1'b1;
      end
      if (cmd.div_step) begin
        rem     <= trial_ge ? MANT_W'(trial - {1'b0, den}) : trial[MANT_W-1:0];
        num     <= {num[NUM_W-2:0], trial_ge};
        bit_cnt <= bit_cnt - 1'b1;
      end
      if (cmd.digit) begin
        num       <= {num[NUM_W-9:0], cq};
        dr        <= 4'(cv - cprod);
        chunk_cnt <= chunk_cnt + 1'b1;
      end
      if (cmd.eval_top || cmd.eval_low) begin
        if (take) begin
          best   <= num[MANT_W-1:0] + MANT_W'(up);
          best_s <= s_cur;
        end
        found     <= found | fits;
        sticky    <= !exact;
        dr        <= '0;
        chunk_cnt <= '0;
        if (s_cur == '0) equal <= exact && (num == NUM_W'(1));
        else s_cur <= s_cur - 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    res_next = '0;
    if (zdiv) begin
      res_next.status = ST_DIV_ZERO;
    end else if (zdnd) begin
      res_next.status = ST_OK;
    end else if (equal) begin
      res_next.quotient_low      = 64'd1;
      res_next.quotient_negative = neg;
    end else if (!found) begin
      res_next.status = neg ? ST_NEG_OVF : ST_POS_OVF;
    end else begin
      res_next.quotient_low      = best[63:0];
      res_next.quotient_high     = best[MANT_W-1:64];
      res_next.quotient_scale    = best_s;
      res_next.quotient_negative = neg && (best != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_payload <= res_next;
    end
  end

  always_comb begin
    stat.trivial    = zdiv || zdnd;
    stat.mul_done   = (mul_cnt == '0);
    stat.div_last   = (bit_cnt == '0);
    stat.chunk_last = (chunk_cnt == CC_W'(CHUNKS - 1));
    stat.scale_zero = (s_cur == '0);
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

@@ rtl/scaled_decimal_divider.sv @@
// Zero divisor or zero dividend: scaling and division are skipped. One item in
//   flight at a time; the time is set by the bit-serial long division and the
//   byte-wide divide-by-ten.
// A finished item waits in the output register while the next one is taken.
// Reset: synchronous, active high; clears controller state and output valid.
// ----------------------------------------------------------------------------
// Scaled decimal divider
// Divides two 96-bit decimal numbers, rounding half to even.
// ----------------------------------------------------------------------------
module scaled_decimal_divider #(
  parameter int MAX_SCALE = 28
) (
  input  logic          clk,
  input  logic          rst,
  sdd_stream_if.sink    operands,
  sdd_stream_if.source  result
);
  import sdd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (operands.valid),
    .in_ready (operands.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sdd_datapath #(.MAX_SCALE(MAX_SCALE)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_payload  (operands.payload),
    .out_payload (result.payload),
    .out_valid   (result.valid),
    .out_ready   (result.ready)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    operands.valid && operands.ready |=> !operands.ready)
    else $error("input taken while an item is in progress");

  a_fault_clears: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.payload.status != ST_OK) |->
      (result.payload.quotient_low == '0) && (result.payload.quotient_high == '0) &&
      (result.payload.quotient_scale == '0) && !result.payload.quotient_negative)
    else $error("fault result carries a quotient");

  a_scale_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.payload.quotient_scale <= SCALE_W'(MAX_SCALE))
    else $error("quotient scale out of range");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!result.valid || result.ready))
    else $error("result overwritten before it was taken");
`endif

endmodule
